[hdl/hpt_pkg.sv]
// Shared types and constants for the homogeneous point transform.
package hpt_pkg;

   localparam int COMPONENTS = 4;
   localparam int COMP_W     = 16;
   localparam int FRAC_BITS  = 8;
   localparam int ROW_W      = COMPONENTS * COMP_W;
   localparam int CSR_IDX_W  = $clog2(COMPONENTS);
   localparam int PROD_W     = 2 * COMP_W;
   localparam int SUM_W      = PROD_W + $clog2(COMPONENTS);

   // Q8.8 unity coefficient, used for the identity matrix at reset
   localparam logic [COMP_W-1:0] COEF_ONE = COMP_W'(1 << FRAC_BITS);

   // Saturation bounds, carried at sum width
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (COMP_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

   // One point or one matrix column, element 0 in the low bits
   typedef logic [COMPONENTS-1:0][COMP_W-1:0] vec_type;

   // Stage enables handed to every lane
   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } lane_ctrl_type;

   // What one lane finds for its output component
   typedef struct packed {
      logic [COMP_W-1:0] value;
      logic              sat;
   } lane_out_type;

endpackage

[hdl/hpt_lane.sv]
// One output component: four products, then sum, shift and saturate.
module hpt_lane
   import hpt_pkg::*;
(
   input  logic          clock,
   input  lane_ctrl_type ctrl,
   input  vec_type       point,
   input  vec_type       coefs,
   output lane_out_type  result
);

   logic signed [PROD_W-1:0] prod_ff [COMPONENTS];
   logic signed [PROD_W-1:0] prod_in [COMPONENTS];
   lane_out_type             result_ff;
   lane_out_type             result_in;

   always_comb begin
      for (int k = 0; k < COMPONENTS; k++) begin
         prod_in[k] = $signed(point[k]) * $signed(coefs[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Exact sum, arithmetic shift (floor), clip to 16 bits
   always_comb begin
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] shifted;
      sum = '0;
      for (int k = 0; k < COMPONENTS; k++) begin
         sum = sum + SUM_W'(prod_ff[k]);
      end
      shifted = sum >>> FRAC_BITS;
      if (shifted > SAT_HI) begin
         result_in.value = SAT_HI[COMP_W-1:0];
         result_in.sat   = 1'b1;
      end else if (shifted < SAT_LO) begin
         result_in.value = SAT_LO[COMP_W-1:0];
         result_in.sat   = 1'b1;
      end else begin
         result_in.value = shifted[COMP_W-1:0];
         result_in.sat   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[hdl/hpt_merge.sv]
// Output register: gathers the lane components and merges their clip flags.
module hpt_merge
   import hpt_pkg::*;
(
   input  logic         clock,
   input  logic         load,
   input  lane_out_type lanes [COMPONENTS],
   output vec_type      value,
   output logic         saturated
);

   vec_type value_ff;
   vec_type value_in;
   logic    sat_ff;
   logic    sat_in;

   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < COMPONENTS; i++) begin
         value_in[i] = lanes[i].value;
         sat_in      = sat_in | lanes[i].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

   assign value     = value_ff;
   assign saturated = sat_ff;

endmodule

[hdl/homogeneous_point_transform.sv]
// Top level of the homogeneous point transform: matrix registers, lanes, flow control.
//
// Usage
//   Request beats carry one point (x, y, z, w) in signed Q8.8. Each point is
//   multiplied as a row vector by the 4x4 matrix held in the four row
//   registers; the response beat carries the four transformed components,
//   floored after the fixed-point shift and clipped to 16 bits, plus a flag
//   that is set when any component was clipped.
//   The matrix is written through csr_write / csr_index / csr_wdata, one row
//   per write, column 0 in the low 16 bits. Write it only while no point is
//   in flight.
// Timing
//   A point accepted at one clock edge passes through the multiply stage,
//   the sum and clip stage and then the output register before it is shown
//   on rsp_valid. One point per cycle is taken for as long as the receiver
//   keeps up; four lanes of four 16x16 multipliers each do the work in
//   parallel.
// Reset and stall
//   Reset empties the pipeline and loads the identity matrix. When the
//   receiver stalls, the response beat holds and earlier stages keep
//   filling; req_stall rises only once every stage holds a point.
module homogeneous_point_transform
   import hpt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [ROW_W-1:0]        csr_wdata,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [COMP_W-1:0] req_in_x,
   input  logic signed [COMP_W-1:0] req_in_y,
   input  logic signed [COMP_W-1:0] req_in_z,
   input  logic signed [COMP_W-1:0] req_in_w,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [COMP_W-1:0] rsp_out_x,
   output logic signed [COMP_W-1:0] rsp_out_y,
   output logic signed [COMP_W-1:0] rsp_out_z,
   output logic signed [COMP_W-1:0] rsp_out_w,
   output logic                    rsp_saturated
);

   // ---------------------------------------------------------------------
   // Matrix rows
   // ---------------------------------------------------------------------
   logic [ROW_W-1:0] row_ff [COMPONENTS];
   logic [ROW_W-1:0] row_in [COMPONENTS];

   always_comb begin
      row_in = row_ff;
      if (csr_write) begin
         row_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // identity: unity on the diagonal
         for (int j = 0; j < COMPONENTS; j++) begin
            row_ff[j] <= ROW_W'(COEF_ONE) << (COMP_W * j);
         end
      end else begin
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage valids and advance terms (bubbles collapse)
   // ---------------------------------------------------------------------
   logic          mul_vld_ff, mul_vld_in;
   logic          sum_vld_ff, sum_vld_in;
   logic          out_vld_ff, out_vld_in;
   logic          out_adv, sum_adv, mul_adv;
   lane_ctrl_type lane_ctrl;

   assign out_adv = !out_vld_ff || !rsp_stall;
   assign sum_adv = !sum_vld_ff || out_adv;
   assign mul_adv = !mul_vld_ff || sum_adv;

   // advance each stage only into room downstream
   always_comb begin
      mul_vld_in = mul_adv ? req_valid  : mul_vld_ff;
      sum_vld_in = sum_adv ? mul_vld_ff : sum_vld_ff;
      out_vld_in = out_adv ? sum_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         sum_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= mul_vld_in;
         sum_vld_ff <= sum_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign lane_ctrl.mul_en = mul_adv;
   assign lane_ctrl.sum_en = sum_adv;
   assign req_stall        = !mul_adv;

   // ---------------------------------------------------------------------
   // Lanes: lane i forms output component i from matrix column i
   // ---------------------------------------------------------------------
   vec_type      point;
   vec_type      lane_coefs [COMPONENTS];
   lane_out_type lane_res   [COMPONENTS];

   assign point = {req_in_w, req_in_z, req_in_y, req_in_x};

   for (genvar i = 0; i < COMPONENTS; i++) begin : g_lane
      always_comb begin
         for (int j = 0; j < COMPONENTS; j++) begin
            lane_coefs[i][j] = row_ff[j][COMP_W*i +: COMP_W];
         end
      end

      hpt_lane u_lane (
         .clock  (clock),
         .ctrl   (lane_ctrl),
         .point  (point),
         .coefs  (lane_coefs[i]),
         .result (lane_res[i])
      );
   end

   // ---------------------------------------------------------------------
   // Merge into the response register
   // ---------------------------------------------------------------------
   vec_type out_value;

   hpt_merge u_merge (
      .clock     (clock),
      .load      (out_adv),
      .lanes     (lane_res),
      .value     (out_value),
      .saturated (rsp_saturated)
   );

   assign rsp_valid = out_vld_ff;
   assign rsp_out_x = out_value[0];
   assign rsp_out_y = out_value[1];
   assign rsp_out_z = out_value[2];
   assign rsp_out_w = out_value[3];

endmodule

[hdl/hpt_checker.sv]
// Port-level checks for the homogeneous point transform, bound to the top level.
module hpt_checker
   import hpt_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [COMP_W-1:0] rsp_out_x,
   input logic signed [COMP_W-1:0] rsp_out_y,
   input logic signed [COMP_W-1:0] rsp_out_z,
   input logic signed [COMP_W-1:0] rsp_out_w,
   input logic                     rsp_saturated
);

   // a stalled response beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // and its payload does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_x) && $stable(rsp_out_y) &&
         $stable(rsp_out_z) && $stable(rsp_out_w) && $stable(rsp_saturated))
      else $error("stalled response payload changed");

   // reset leaves nothing to deliver
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // requests are held off only when the response side is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with room in the pipeline");

   // a free-flowing accepted point reaches the response port
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted point did not reach the response port");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (.*);
